### rtl/rsfp_pkg.sv
// ----------------------------------------------------------------------------
// rsfp_pkg
// Shared types and constants for the range sensor frame parser.
// ----------------------------------------------------------------------------
package rsfp_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 16;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);

  typedef logic [POS_W-1:0] pos_t;

  // Byte offsets inside a frame
  localparam pos_t POS_HEADER    = POS_W'(0);
  localparam pos_t POS_FUNCTION  = POS_W'(1);
  localparam pos_t POS_ID        = POS_W'(3);
  localparam pos_t POS_TIME0     = POS_W'(4);
  localparam pos_t POS_TIME1     = POS_W'(5);
  localparam pos_t POS_TIME2     = POS_W'(6);
  localparam pos_t POS_TIME3     = POS_W'(7);
  localparam pos_t POS_DIST0     = POS_W'(8);
  localparam pos_t POS_DIST1     = POS_W'(9);
  localparam pos_t POS_DIST2     = POS_W'(10);
  localparam pos_t POS_STATUS    = POS_W'(11);
  localparam pos_t POS_STRENGTH0 = POS_W'(12);
  localparam pos_t POS_STRENGTH1 = POS_W'(13);
  localparam pos_t POS_PRECISION = POS_W'(14);
  localparam pos_t POS_CHECKSUM  = POS_W'(FRAME_BYTES - 1);
  localparam pos_t POS_DONE      = POS_W'(FRAME_BYTES);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_HEADER   = 1'b0,
    REG_FUNCTION = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] HEADER_RESET   = 8'h57;
  localparam logic [7:0] FUNCTION_RESET = 8'h00;

  // One decoded frame
  typedef struct packed {
    logic [7:0]         precision_val;
    logic [15:0]        rx_strength;
    logic [7:0]         distance_status;
    logic signed [23:0] distance_mm;
    logic [31:0]        uptime_ms;
    logic [7:0]         sensor_id;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

### rtl/rsfp_parser.sv
// ----------------------------------------------------------------------------
// rsfp_parser
// Per-byte frame parser: position counter, running checksum, header and
// function checks and little-endian field capture. Flags a result on the checksum byte.
// ----------------------------------------------------------------------------
module rsfp_parser
  import rsfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  cfg_reg_t   cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       byte_fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output logic       res_valid,
  output result_t    res_data
);

  logic [7:0]         header_r,   header_nxt;
  logic [7:0]         function_r, function_nxt;
  pos_t               pos_r,      pos_nxt;
  logic [7:0]         sum_r,      sum_nxt;
  logic               good_r,     good_nxt;
  logic [7:0]         id_r,       id_nxt;
  logic [31:0]        time_r,     time_nxt;
  logic signed [23:0] dist_r,     dist_nxt;
  logic [7:0]         status_r,   status_nxt;
  logic [15:0]        strength_r, strength_nxt;
  logic [7:0]         prec_r,     prec_nxt;
  logic               emit;

  // Configuration register writes
  always_comb begin
    header_nxt   = header_r;
    function_nxt = function_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_HEADER:   header_nxt   = cfg_wdata;
        REG_FUNCTION: function_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame parsing for one accepted byte
  always_comb begin
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    good_nxt     = good_r;
    id_nxt       = id_r;
    time_nxt     = time_r;
    dist_nxt     = dist_r;
    status_nxt   = status_r;
    strength_nxt = strength_r;
    prec_nxt     = prec_r;
    emit         = 1'b0;
    if (byte_fire) begin
      if (pos_r < POS_DONE) begin
        case (pos_r)
          POS_HEADER:    if (data_byte != header_r)   good_nxt = 1'b0;
          POS_FUNCTION:  if (data_byte != function_r) good_nxt = 1'b0;
          POS_ID:        id_nxt              = data_byte;
          POS_TIME0:     time_nxt[7:0]       = data_byte;
          POS_TIME1:     time_nxt[15:8]      = data_byte;
          POS_TIME2:     time_nxt[23:16]     = data_byte;
          POS_TIME3:     time_nxt[31:24]     = data_byte;
          POS_DIST0:     dist_nxt[7:0]       = data_byte;
          POS_DIST1:     dist_nxt[15:8]      = data_byte;
          POS_DIST2:     dist_nxt[23:16]     = data_byte;
          POS_STATUS:    status_nxt          = data_byte;
          POS_STRENGTH0: strength_nxt[7:0]   = data_byte;
          POS_STRENGTH1: strength_nxt[15:8]  = data_byte;
          POS_PRECISION: prec_nxt            = data_byte;
          default: ;
        endcase
        // checksum byte closes the frame; all others add to the sum
        if (pos_r == POS_CHECKSUM) begin
          emit = good_r && (sum_r == data_byte);
        end else begin
          sum_nxt = sum_r + data_byte;
        end
        pos_nxt = pos_r + POS_W'(1);
      end
      // restart on the last byte of a buffer; captures are kept
      if (end_of_buffer) begin
        pos_nxt  = '0;
        sum_nxt  = '0;
        good_nxt = 1'b1;
      end
    end
  end

  // Control and capture registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r   <= HEADER_RESET;
      function_r <= FUNCTION_RESET;
      pos_r      <= '0;
      sum_r      <= '0;
      good_r     <= 1'b1;
      id_r       <= '0;
      time_r     <= '0;
      dist_r     <= '0;
      status_r   <= '0;
      strength_r <= '0;
      prec_r     <= '0;
    end else begin
      header_r   <= header_nxt;
      function_r <= function_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      good_r     <= good_nxt;
      id_r       <= id_nxt;
      time_r     <= time_nxt;
      dist_r     <= dist_nxt;
      status_r   <= status_nxt;
      strength_r <= strength_nxt;
      prec_r     <= prec_nxt;
    end
  end

  // Result fields are complete once byte 14 is in
  assign res_valid                = emit;
  assign res_data.sensor_id       = id_r;
  assign res_data.uptime_ms       = time_r;
  assign res_data.distance_mm     = dist_r;
  assign res_data.distance_status = status_r;
  assign res_data.rx_strength     = strength_r;
  assign res_data.precision_val   = prec_r;

endmodule

### rtl/rsfp_out_queue.sv
// ----------------------------------------------------------------------------
// rsfp_out_queue
// Two-entry result register queue; decouples the output stall from the
// input side so bytes keep flowing while a result waits.
// ----------------------------------------------------------------------------
module rsfp_out_queue
  import rsfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    not_full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign not_full  = (cnt_r != CNT_W'(DEPTH));
  assign out_data  = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/range_sensor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// range_sensor_frame_parser_top
// Parses 16-byte sensor frames; one request per frame passing all checks.
// Throughput: one byte per cycle; in_tready drops only while both output
// queue entries hold results. A result is queued as its checksum byte is
// taken and shown after older ones. Synchronous reset restores header 0x57,
// function 0x00, restarts parsing and empties the output queue.
// ----------------------------------------------------------------------------
module range_sensor_frame_parser_top
  import rsfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  // byte stream in
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tlast,   // end_of_buffer
  // frame results out
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [RESULT_W-1:0] out_tdata   // [7:0] sensor_id, [39:8] uptime_ms,
                                          // [63:40] distance_mm,
                                          // [71:64] distance_status,
                                          // [87:72] rx_strength,
                                          // [95:88] precision_val
);

  logic     byte_fire;
  logic     res_valid;
  result_t  res_data;
  result_t  q_data;

  assign byte_fire = in_tvalid && in_tready;

  rsfp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_reg_t'(cfg_index)),
    .cfg_wdata     (cfg_wdata),
    .byte_fire     (byte_fire),
    .data_byte     (in_tdata),
    .end_of_buffer (in_tlast),
    .res_valid     (res_valid),
    .res_data      (res_data)
  );

  rsfp_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .not_full  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  // struct layout already puts sensor_id in the lowest bits
  assign out_tdata = q_data;

endmodule

### tb/range_sensor_frame_parser_top_tb.sv
// ----------------------------------------------------------------------------
// range_sensor_frame_parser_top_tb
// Streams byte buffers into the frame parser: well-formed frames with random
// content, frames with a bad header, function or checksum byte, short buffers,
// long buffers and random noise. The header and function registers are
// changed between phases. A local frame decoder predicts every result, and
// each result request is checked field by field against the oldest
// prediction. Source gaps and sink stalls are varied from phase to phase.
// ----------------------------------------------------------------------------
module range_sensor_frame_parser_top_tb
  import rsfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // Ways a frame can be damaged on purpose
  typedef enum int {
    FAULT_NONE,
    FAULT_HEADER,
    FAULT_FUNCTION,
    FAULT_SUM
  } fault_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_wr_en  = 1'b0;
  logic [0:0]          cfg_index  = REG_HEADER;
  logic [7:0]          cfg_wdata  = 8'h00;
  logic                in_tvalid  = 1'b0;
  logic [7:0]          in_tdata   = 8'h00;
  logic                in_tlast   = 1'b0;
  logic                out_tready = 1'b0;
  logic                in_tready;
  logic                out_tvalid;
  logic [RESULT_W-1:0] out_tdata;

  range_sensor_frame_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stimulus bookkeeping
  stream_byte_t pending_bytes[$];
  result_t      expected_frames[$];
  int           bytes_queued   = 0;
  int           bytes_taken    = 0;
  int           src_idle_pct   = 0;
  int           sink_stall_pct = 0;
  int           errors         = 0;
  int           cycles         = 0;
  logic         in_fire        = 1'b0;

  // Register values the stimulus builds frames for
  logic [7:0]   stim_header    = HEADER_RESET;
  logic [7:0]   stim_function  = FUNCTION_RESET;

  // Decoder state mirrored from the block
  logic [7:0]   dec_header     = HEADER_RESET;
  logic [7:0]   dec_function   = FUNCTION_RESET;
  pos_t         dec_pos        = '0;
  logic [7:0]   dec_sum        = 8'h00;
  logic         dec_ok         = 1'b1;
  result_t      dec_fields     = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Decode one accepted byte; a good checksum byte yields a frame result
  task automatic decode_byte(input logic [7:0] b, input logic last);
    if (dec_pos < POS_DONE) begin
      case (dec_pos)
        POS_HEADER:    if (b != dec_header) dec_ok = 1'b0;
        POS_FUNCTION:  if (b != dec_function) dec_ok = 1'b0;
        POS_ID:        dec_fields.sensor_id = b;
        POS_TIME0:     dec_fields.uptime_ms[7:0] = b;
        POS_TIME1:     dec_fields.uptime_ms[15:8] = b;
        POS_TIME2:     dec_fields.uptime_ms[23:16] = b;
        POS_TIME3:     dec_fields.uptime_ms[31:24] = b;
        POS_DIST0:     dec_fields.distance_mm[7:0] = b;
        POS_DIST1:     dec_fields.distance_mm[15:8] = b;
        POS_DIST2:     dec_fields.distance_mm[23:16] = b;
        POS_STATUS:    dec_fields.distance_status = b;
        POS_STRENGTH0: dec_fields.rx_strength[7:0] = b;
        POS_STRENGTH1: dec_fields.rx_strength[15:8] = b;
        POS_PRECISION: dec_fields.precision_val = b;
        default: ;
      endcase
      if (dec_pos == POS_CHECKSUM) begin
        if (dec_ok && dec_sum == b) expected_frames.push_back(dec_fields);
      end else begin
        dec_sum = dec_sum + b;
      end
      dec_pos = dec_pos + POS_W'(1);
    end
    // captures survive the end of a buffer, the scan does not
    if (last) begin
      dec_pos = '0;
      dec_sum = 8'h00;
      dec_ok  = 1'b1;
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    stream_byte_t sb;
    sb.data = data;
    sb.last = last;
    pending_bytes.push_back(sb);
    bytes_queued++;
  endtask

  // Queue one buffer carrying a frame; len below 16 truncates, above pads
  task automatic add_frame(input result_t f, input logic [7:0] spare, input int len,
                           input fault_t fault);
    logic [7:0] fr[16];
    logic [7:0] sum;
    fr[0]  = stim_header;
    fr[1]  = stim_function;
    fr[2]  = spare;
    fr[3]  = f.sensor_id;
    fr[4]  = f.uptime_ms[7:0];
    fr[5]  = f.uptime_ms[15:8];
    fr[6]  = f.uptime_ms[23:16];
    fr[7]  = f.uptime_ms[31:24];
    fr[8]  = f.distance_mm[7:0];
    fr[9]  = f.distance_mm[15:8];
    fr[10] = f.distance_mm[23:16];
    fr[11] = f.distance_status;
    fr[12] = f.rx_strength[7:0];
    fr[13] = f.rx_strength[15:8];
    fr[14] = f.precision_val;
    sum = 8'h00;
    for (int i = 0; i < 15; i++) sum = sum + fr[i];
    fr[15] = sum;
    case (fault)
      FAULT_HEADER:   fr[0]  = fr[0] ^ 8'($urandom_range(1, 255));
      FAULT_FUNCTION: fr[1]  = fr[1] ^ 8'($urandom_range(1, 255));
      FAULT_SUM:      fr[15] = fr[15] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    for (int i = 0; i < len; i++)
      push_byte((i < 16) ? fr[i] : 8'($urandom), i == len - 1);
  endtask

  // Random bytes with scattered buffer ends, closed by an end marker
  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom), ($urandom_range(7) == 0) || (i == n - 1));
  endtask

  function automatic result_t rand_frame();
    result_t f;
    f.sensor_id       = 8'($urandom);
    f.uptime_ms       = $urandom;
    f.distance_status = 8'($urandom);
    f.rx_strength     = 16'($urandom);
    f.precision_val   = 8'($urandom);
    case ($urandom_range(3))
      0:       f.distance_mm = 24'h800000;
      1:       f.distance_mm = 24'h7FFFFF;
      default: f.distance_mm = 24'($urandom);
    endcase
    return f;
  endfunction

  // Mostly well-formed frames, the rest damaged, cut short or noise
  task automatic random_phase(input int n_bytes);
    int start;
    int sel;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      sel = $urandom_range(99);
      if (sel < 60)
        add_frame(rand_frame(), 8'($urandom), 16, FAULT_NONE);
      else if (sel < 70)
        add_frame(rand_frame(), 8'($urandom), $urandom_range(17, 24), FAULT_NONE);
      else if (sel < 80)
        add_frame(rand_frame(), 8'($urandom), 16, fault_t'($urandom_range(1, 3)));
      else if (sel < 90)
        add_frame(rand_frame(), 8'($urandom), $urandom_range(1, 15), FAULT_NONE);
      else
        add_noise($urandom_range(1, 12));
    end
  endtask

  // Hold off until every byte is taken and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (!(bytes_taken == bytes_queued && expected_frames.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] hdr, input logic [7:0] fn);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HEADER;
    cfg_wdata <= hdr;
    @(negedge clk);
    cfg_index <= REG_FUNCTION;
    cfg_wdata <= fn;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    stim_header   = hdr;
    stim_function = fn;
  endtask

  // Source and sink: drive on the falling edge
  always @(negedge clk) begin
    stream_byte_t nxt;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: sample handshakes and register writes on the rising edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      in_fire = in_tvalid && in_tready;
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEADER:   dec_header   = cfg_wdata;
          REG_FUNCTION: dec_function = cfg_wdata;
          default: ;
        endcase
      end
      // result request: compare before this edge's byte is decoded
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected result, sensor_id", 32'(got.sensor_id), 32'h0);
        end else begin
          want = expected_frames.pop_front();
          if (got.sensor_id !== want.sensor_id)
            report_mismatch("sensor_id", 32'(got.sensor_id), 32'(want.sensor_id));
          if (got.uptime_ms !== want.uptime_ms)
            report_mismatch("uptime_ms", got.uptime_ms, want.uptime_ms);
          if (got.distance_mm !== want.distance_mm)
            report_mismatch("distance_mm", 32'(got.distance_mm),
                            32'(want.distance_mm));
          if (got.distance_status !== want.distance_status)
            report_mismatch("distance_status", 32'(got.distance_status),
                            32'(want.distance_status));
          if (got.rx_strength !== want.rx_strength)
            report_mismatch("rx_strength", 32'(got.rx_strength),
                            32'(want.rx_strength));
          if (got.precision_val !== want.precision_val)
            report_mismatch("precision_val", 32'(got.precision_val),
                            32'(want.precision_val));
        end
      end
      if (in_fire) begin
        decode_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset register values
    src_idle_pct   = 14;
    sink_stall_pct = 69;
    add_frame({RESULT_W{1'b1}}, 8'hFF, 16, FAULT_NONE);   // all fields all ones
    add_frame('0, 8'h00, 18, FAULT_NONE);                 // long buffer, zero fields
    add_frame(rand_frame(), 8'h5A, 3, FAULT_NONE);        // short buffer
    add_frame(rand_frame(), 8'hA5, 16, FAULT_SUM);        // bad checksum
    wait_drained();

    // register extremes, slow sink
    write_regs(8'h00, 8'hFF);
    random_phase(PHASE_BYTES);
    wait_drained();

    // opposite extremes, slow source
    write_regs(8'hFF, 8'h00);
    src_idle_pct   = 69;
    sink_stall_pct = 14;
    random_phase(PHASE_BYTES);
    wait_drained();

    // random registers, no idling
    write_regs(8'($urandom), 8'($urandom));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_phase(PHASE_BYTES);
    wait_drained();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### range_sensor_frame_parser_top.f
rtl/rsfp_pkg.sv
rtl/rsfp_parser.sv
rtl/rsfp_out_queue.sv
rtl/range_sensor_frame_parser_top.sv
tb/range_sensor_frame_parser_top_tb.sv
